// File: design/gsfc_pkg.sv
// ----------------------------------------------------------------------------
// gsfc_pkg
// shared constants and types of the gas sensor frame checker
// ----------------------------------------------------------------------------
package gsfc_pkg;

  localparam int MAX_FRAME = 64;

  localparam logic [7:0] HDR0 = 8'hFF;
  localparam logic [7:0] HDR1 = 8'h17;
  localparam logic [7:0] HDR2 = 8'h04;

  localparam logic [7:0] POS_HDR0 = 8'd0;
  localparam logic [7:0] POS_HDR1 = 8'd1;
  localparam logic [7:0] POS_HDR2 = 8'd2;
  localparam logic [7:0] POS_VALH = 8'd4;
  localparam logic [7:0] POS_VALL = 8'd5;
  localparam logic [7:0] POS_MAX  = 8'd255;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONC_MAX     = 2'd1;

  localparam logic [7:0]  LINK_TIMEOUT_RST = 8'd10;
  localparam logic [15:0] CONC_MAX_RST     = 16'd2000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] concentration;
    logic        frame_ok;
    logic        link_ok;
  } result_t;

endpackage

// File: design/gsfc_in_if.sv
// ----------------------------------------------------------------------------
// gsfc_in_if
// input channel: received bytes and ticks
// ----------------------------------------------------------------------------
interface gsfc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output cmd, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, input last_byte, output ready);
endinterface

// File: design/gsfc_out_if.sv
// ----------------------------------------------------------------------------
// gsfc_out_if
// result channel: concentration and status flags
// ----------------------------------------------------------------------------
interface gsfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] concentration;
  logic        frame_ok;
  logic        link_ok;

  modport source (output valid, output concentration, output frame_ok, output link_ok,
                  input ready);
  modport sink (input valid, input concentration, input frame_ok, input link_ok,
                output ready);
endinterface

// File: design/gsfc_scale.sv
// ----------------------------------------------------------------------------
// gsfc_scale
// scales the raw reading by 1.25 and saturates it to the ceiling
// ----------------------------------------------------------------------------
module gsfc_scale (
  input  logic [7:0]  value_high_i,
  input  logic [7:0]  value_low_i,
  input  logic [15:0] conc_max_i,
  output logic [15:0] conc_o
);

  logic [15:0] raw;
  logic [16:0] scaled;

  assign raw    = {value_high_i, value_low_i};
  assign scaled = {1'b0, raw} + {3'b000, raw[15:2]};
  assign conc_o = (scaled > {1'b0, conc_max_i}) ? conc_max_i : scaled[15:0];

endmodule

// File: design/gsfc_frame.sv
// ----------------------------------------------------------------------------
// gsfc_frame
// frame tracking, checksum check, latched concentration and link counter
// ----------------------------------------------------------------------------
module gsfc_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  gsfc_pkg::item_t   item_i,
  input  logic [7:0]        link_timeout_i,
  input  logic [15:0]       conc_max_i,
  output gsfc_pkg::result_t result_o
);

  logic [7:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  run_sum_q, run_sum_d;
  logic        header_good_q, header_good_d;
  logic [7:0]  value_high_q, value_high_d;
  logic [7:0]  value_low_q, value_low_d;
  logic [15:0] conc_q, conc_d;
  logic [7:0]  link_count_q, link_count_d;
  logic [15:0] scaled;
  logic        ok;

  gsfc_scale u_scale (
    .value_high_i (value_high_d),
    .value_low_i  (value_low_d),
    .conc_max_i   (conc_max_i),
    .conc_o       (scaled)
  );

  always_comb begin
    byte_pos_d    = byte_pos_q;
    run_sum_d     = run_sum_q;
    header_good_d = header_good_q;
    value_high_d  = value_high_q;
    value_low_d   = value_low_q;
    conc_d        = conc_q;
    link_count_d  = link_count_q;
    ok            = 1'b0;
    if (item_i.cmd == gsfc_pkg::CMD_TICK) begin
      if (link_count_q != 8'd0) begin
        link_count_d = link_count_q - 8'd1;
      end
    end else begin
      case (byte_pos_q)
        gsfc_pkg::POS_HDR0: begin
          header_good_d = (item_i.rx_byte == gsfc_pkg::HDR0);
          run_sum_d     = 8'd0;
        end
        gsfc_pkg::POS_HDR1: header_good_d = header_good_q && (item_i.rx_byte == gsfc_pkg::HDR1);
        gsfc_pkg::POS_HDR2: header_good_d = header_good_q && (item_i.rx_byte == gsfc_pkg::HDR2);
        gsfc_pkg::POS_VALH: value_high_d = item_i.rx_byte;
        gsfc_pkg::POS_VALL: value_low_d  = item_i.rx_byte;
        default: ;
      endcase
      if (item_i.last_byte) begin
        ok = header_good_d && (byte_pos_q >= gsfc_pkg::POS_VALL)
             && (byte_pos_q <= 8'(gsfc_pkg::MAX_FRAME - 1))
             && (item_i.rx_byte == (8'd0 - run_sum_d));
        if (ok) begin
          conc_d       = scaled;
          link_count_d = link_timeout_i;
        end
        byte_pos_d = 8'd0;
      end else begin
        if (byte_pos_q != gsfc_pkg::POS_HDR0) begin
          run_sum_d = run_sum_q + item_i.rx_byte;
        end
        if (byte_pos_q != gsfc_pkg::POS_MAX) begin
          byte_pos_d = byte_pos_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q    <= 8'd0;
      run_sum_q     <= 8'd0;
      header_good_q <= 1'b1;
      value_high_q  <= 8'd0;
      value_low_q   <= 8'd0;
      conc_q        <= 16'd0;
      link_count_q  <= gsfc_pkg::LINK_TIMEOUT_RST;
    end else if (step_i) begin
      byte_pos_q    <= byte_pos_d;
      run_sum_q     <= run_sum_d;
      header_good_q <= header_good_d;
      value_high_q  <= value_high_d;
      value_low_q   <= value_low_d;
      conc_q        <= conc_d;
      link_count_q  <= link_count_d;
    end
  end

  assign result_o.concentration = conc_d;
  assign result_o.frame_ok      = ok;
  assign result_o.link_ok       = (link_count_d != 8'd0);

endmodule

// File: design/gas_sensor_frame_checker.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_checker
// checks sensor reply frames, scales the reading and tracks link health
// ----------------------------------------------------------------------------
// in_i carries one item per transfer: a received byte (cmd 0, with last_byte
// marking the end of a frame) or a time tick (cmd 1). out_o returns exactly
// one result per item: the latched concentration, frame_ok for an item that
// completed a good frame, and link_ok while the link counter is nonzero.
// An item is captured in an input register and its result then lands in the
// result register, which drives out_o.valid. One item per cycle is sustained
// while out_o.ready stays high; the path between the two registers holds
// the frame checks, the 1.25 scale and the saturation.
// A stalled receiver holds the result; one more item waits in the input
// register, and in_i.ready drops only when both are full.
// Reset empties both registers, restarts frame tracking, clears the
// concentration and loads link_timeout 10 and conc_max 2000, with the link
// counter at 10. The user must write registers through cfg_we_i / cfg_idx_i /
// cfg_wdata_i only while no item is in flight; the block itself does not
// enforce this. Other indexes are ignored.
// ----------------------------------------------------------------------------
module gas_sensor_frame_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gsfc_in_if.sink                          in_i,
  gsfc_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [gsfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gsfc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic              s1_valid_q, s1_valid_d;
  gsfc_pkg::item_t   s1_item_q;
  logic              out_valid_q, out_valid_d;
  gsfc_pkg::result_t out_res_q;
  gsfc_pkg::result_t res;
  logic              s1_adv;
  logic              in_xfer;
  logic [7:0]        link_timeout_q;
  logic [15:0]       conc_max_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.cmd       <= in_i.cmd;
      s1_item_q.rx_byte   <= in_i.rx_byte;
      s1_item_q.last_byte <= in_i.last_byte;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_timeout_q <= gsfc_pkg::LINK_TIMEOUT_RST;
      conc_max_q     <= gsfc_pkg::CONC_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gsfc_pkg::CFG_LINK_TIMEOUT: link_timeout_q <= cfg_wdata_i[7:0];
        gsfc_pkg::CFG_CONC_MAX:     conc_max_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gsfc_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s1_adv),
    .item_i         (s1_item_q),
    .link_timeout_i (link_timeout_q),
    .conc_max_i     (conc_max_q),
    .result_o       (res)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.concentration = out_res_q.concentration;
  assign out_o.frame_ok      = out_res_q.frame_ok;
  assign out_o.link_ok       = out_res_q.link_ok;

  // a buffered item is kept while the result register is stalled
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_o.ready |=> s1_valid_q)
    else $error("buffered item lost during stall");

  // a new transfer into a full input register must coincide with its advance
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s1_valid_q |-> s1_adv)
    else $error("input register overwritten");

  // an advanced item always produces a pending result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("result not presented after advance");

endmodule

// File: test/tb_gas_sensor_frame_checker.sv
// ----------------------------------------------------------------------------
// tb_gas_sensor_frame_checker
// self-checking bench for the gas sensor frame checker
// ----------------------------------------------------------------------------
// Sends received bytes and time ticks through the input channel and predicts
// every result in step with each input transfer. The prediction tracks frame
// position, checksum, header match, scaled and saturated concentration and
// the link counter. Results are compared field by field in order.
// Directed frames and register writes come first, then phases of random
// traffic under different register settings. The traffic mixes good frames
// with bad checksums, bad headers, short and long frames, stray bytes and
// ticks. Sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gas_sensor_frame_checker;
  import gsfc_pkg::*;

  localparam int MIN_FRAME_LEN = 6;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASES = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    TR_GOOD, TR_BAD_SUM, TR_BAD_HDR, TR_SHORT, TR_LONG, TR_NOISE, TR_TICKS
  } traffic_e;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_CADENCE, RX_LONG_STALL} rx_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gsfc_in_if  in_if ();
  gsfc_out_if out_if ();

  gas_sensor_frame_checker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // predicted block state
  logic [7:0]  trk_pos;
  logic [7:0]  trk_sum;
  logic        trk_hdr_ok;
  logic [7:0]  trk_val_hi;
  logic [7:0]  trk_val_lo;
  logic [15:0] held_conc;
  logic [7:0]  link_ticks_left;
  logic [7:0]  set_timeout;
  logic [15:0] set_ceiling;

  result_t    pending_reports[$];
  logic [7:0] frame_buf[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         burst_left = 1;
  bit         sending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void reset_model();
    trk_pos         = 8'd0;
    trk_sum         = 8'd0;
    trk_hdr_ok      = 1'b1;
    trk_val_hi      = 8'd0;
    trk_val_lo      = 8'd0;
    held_conc       = 16'd0;
    link_ticks_left = LINK_TIMEOUT_RST;
    set_timeout     = LINK_TIMEOUT_RST;
    set_ceiling     = CONC_MAX_RST;
  endfunction

  function automatic result_t sensor_next_report(item_t it);
    logic [7:0]  pos;
    logic [7:0]  want_sum;
    logic [15:0] raw;
    logic [16:0] scaled;
    logic        good;
    result_t     r;
    good = 1'b0;
    if (it.cmd == CMD_TICK) begin
      if (link_ticks_left != 8'd0) link_ticks_left = link_ticks_left - 8'd1;
    end else begin
      pos = trk_pos;
      case (pos)
        POS_HDR0: begin
          trk_hdr_ok = (it.rx_byte == HDR0);
          trk_sum    = 8'd0;
        end
        POS_HDR1: trk_hdr_ok = trk_hdr_ok && (it.rx_byte == HDR1);
        POS_HDR2: trk_hdr_ok = trk_hdr_ok && (it.rx_byte == HDR2);
        POS_VALH: trk_val_hi = it.rx_byte;
        POS_VALL: trk_val_lo = it.rx_byte;
        default: ;
      endcase
      if (it.last_byte) begin
        want_sum = 8'd0 - trk_sum;
        good = trk_hdr_ok && (int'(pos) + 1 >= MIN_FRAME_LEN)
               && (int'(pos) + 1 <= MAX_FRAME) && (it.rx_byte == want_sum);
        if (good) begin
          raw    = {trk_val_hi, trk_val_lo};
          scaled = {1'b0, raw} + {3'b000, raw[15:2]};
          held_conc = (scaled > {1'b0, set_ceiling}) ? set_ceiling : scaled[15:0];
          link_ticks_left = set_timeout;
        end
        trk_pos = 8'd0;
      end else begin
        if (pos != POS_HDR0) trk_sum = trk_sum + it.rx_byte;
        if (pos != POS_MAX) trk_pos = pos + 8'd1;
      end
    end
    r.concentration = held_conc;
    r.frame_ok      = good;
    r.link_ok       = (link_ticks_left != 8'd0);
    return r;
  endfunction

  function automatic void check_report();
    result_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result conc %0d frame_ok %0b link_ok %0b", $time,
               out_if.concentration, out_if.frame_ok, out_if.link_ok);
      return;
    end
    want = pending_reports.pop_front();
    if (out_if.concentration !== want.concentration) begin
      mismatches++;
      $display("%0t: concentration expected %0d actual %0d", $time,
               want.concentration, out_if.concentration);
    end
    if (out_if.frame_ok !== want.frame_ok) begin
      mismatches++;
      $display("%0t: frame_ok expected %0b actual %0b", $time, want.frame_ok, out_if.frame_ok);
    end
    if (out_if.link_ok !== want.link_ok) begin
      mismatches++;
      $display("%0t: link_ok expected %0b actual %0b", $time, want.link_ok, out_if.link_ok);
    end
  endfunction

  // result side: checks each transfer and stalls on a changing pattern
  initial begin : result_sink
    rx_mode_e mode;
    int       mode_left;
    int       stall_left;
    int       cyc;
    mode       = RX_STEADY;
    mode_left  = 0;
    stall_left = 0;
    cyc        = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_report();
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        RX_STEADY: out_if.ready <= 1'b1;
        RX_COIN: out_if.ready <= ($urandom_range(0, 99) < 60);
        RX_CADENCE: out_if.ready <= ((cyc % 7) < 4);
        default: begin
          if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 16);
          if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] rx, input logic is_last);
    item_t it;
    int    gap;
    it.cmd       = cmd;
    it.rx_byte   = rx;
    it.last_byte = is_last;
    in_if.valid     <= 1'b1;
    in_if.cmd       <= cmd;
    in_if.rx_byte   <= rx;
    in_if.last_byte <= is_last;
    sending = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_reports.push_back(sensor_next_report(it));
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1: gap = 0;
        2: gap = $urandom_range(10, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        sending = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle(input int settle);
    if (sending) begin
      in_if.valid <= 1'b0;
      sending = 1'b0;
    end
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LINK_TIMEOUT: set_timeout = data[7:0];
      CFG_CONC_MAX: set_ceiling = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // last byte becomes the two's-complement checksum of bytes 1 .. n-2
  function automatic void seal_frame();
    logic [7:0] s;
    s = 8'd0;
    for (int i = 1; i < frame_buf.size() - 1; i++) s = s + frame_buf[i];
    frame_buf[frame_buf.size() - 1] = 8'd0 - s;
  endfunction

  function automatic void build_frame(input logic [15:0] raw, input int len);
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      case (i)
        POS_HDR0: frame_buf.push_back(HDR0);
        POS_HDR1: frame_buf.push_back(HDR1);
        POS_HDR2: frame_buf.push_back(HDR2);
        POS_VALH: frame_buf.push_back(raw[15:8]);
        POS_VALL: frame_buf.push_back(raw[7:0]);
        default: frame_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    seal_frame();
  endfunction

  task automatic send_frame(input bit mix_ticks);
    int n;
    n = frame_buf.size();
    for (int i = 0; i < n; i++) begin
      if (mix_ticks && $urandom_range(0, 19) == 0)
        send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(CMD_BYTE, frame_buf[i], i == n - 1);
    end
  endtask

  function automatic logic [15:0] pick_raw();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 2047);
      2: begin
        v = int'(set_ceiling) * 4 / 5 + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 65535;
          2: v = 16'hCCCC;
          default: v = 1;
        endcase
      end
    endcase
    return 16'(v);
  endfunction

  function automatic int good_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(13, MAX_FRAME);
    return $urandom_range(MIN_FRAME_LEN, 12);
  endfunction

  task automatic test_directed();
    send_item(CMD_TICK, 8'h00, 1'b0);
    build_frame(16'hFFFF, 7);
    send_frame(1'b0);
    build_frame(16'h0123, MIN_FRAME_LEN);
    send_frame(1'b0);
    build_frame(16'h0040, MIN_FRAME_LEN - 1);
    send_frame(1'b0);
    send_item(CMD_TICK, 8'hFF, 1'b1);
    wait_idle(4);
  endtask

  task automatic test_registers();
    write_reg(CFG_LINK_TIMEOUT, 16'hFF01);
    write_reg(CFG_CONC_MAX, 16'h0000);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h5A5A);
    build_frame(16'h1234, 8);
    send_frame(1'b0);
    repeat (3) send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0);
    wait_idle(4);
    write_reg(CFG_LINK_TIMEOUT, 16'h0000);
    build_frame(16'h0800, MIN_FRAME_LEN);
    send_frame(1'b0);
    wait_idle(4);
    write_reg(CFG_LINK_TIMEOUT, 16'h00FF);
    write_reg(CFG_CONC_MAX, 16'hFFFF);
    build_frame(16'hCCCC, 9);
    send_frame(1'b0);
    build_frame(16'hFFFF, 7);
    send_frame(1'b0);
    build_frame(pick_raw(), MAX_FRAME);
    send_frame(1'b0);
    build_frame(pick_raw(), MAX_FRAME + 1);
    send_frame(1'b0);
    send_item(CMD_TICK, 8'h5A, 1'b0);
    wait_idle(4);
  endtask

  task automatic test_random_traffic(input int timeout_val, input int ceiling_val,
                                     input int n_items, input bit pause_midway);
    int       start;
    int       len;
    int       pick;
    int       n;
    bit       paused;
    traffic_e kind;
    paused = 1'b0;
    wait_idle(4);
    write_reg(CFG_LINK_TIMEOUT, {8'($urandom_range(0, 255)), 8'(timeout_val)});
    write_reg(CFG_CONC_MAX, 16'(ceiling_val));
    start = items_sent;
    while (items_sent - start < n_items) begin
      if (pause_midway && !paused && items_sent - start >= n_items / 2) begin
        wait_idle(0);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = TR_GOOD;
      else if (pick < 60) kind = TR_BAD_SUM;
      else if (pick < 68) kind = TR_BAD_HDR;
      else if (pick < 75) kind = TR_SHORT;
      else if (pick < 79) kind = TR_LONG;
      else if (pick < 85) kind = TR_NOISE;
      else kind = TR_TICKS;
      case (kind)
        TR_GOOD: begin
          build_frame(pick_raw(), good_len());
          send_frame(1'b1);
        end
        TR_BAD_SUM: begin
          build_frame(pick_raw(), good_len());
          frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(1, 255));
          send_frame(1'b1);
        end
        TR_BAD_HDR: begin
          build_frame(pick_raw(), good_len());
          frame_buf[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
          seal_frame();
          send_frame(1'b1);
        end
        TR_SHORT: begin
          build_frame(pick_raw(), $urandom_range(1, MIN_FRAME_LEN - 1));
          send_frame(1'b1);
        end
        TR_LONG: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(250, 300)
                                            : $urandom_range(MAX_FRAME + 1, MAX_FRAME + 6);
          build_frame(pick_raw(), len);
          send_frame(1'b1);
        end
        TR_NOISE: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            send_item(CMD_BYTE, 8'($urandom_range(0, 255)),
                      (i == n - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0));
        end
        default: begin
          repeat ($urandom_range(1, 4))
            send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.cmd       <= CMD_BYTE;
    in_if.rx_byte   <= 8'd0;
    in_if.last_byte <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_LINK_TIMEOUT;
    cfg_wdata       <= '0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_registers();
    test_random_traffic(1, 0, RANDOM_ITEMS / PHASES, 1'b0);
    test_random_traffic(255, 65535, RANDOM_ITEMS / PHASES, 1'b1);
    test_random_traffic($urandom_range(1, 255), $urandom_range(0, 65535),
                        RANDOM_ITEMS / PHASES, 1'b0);
    test_random_traffic($urandom_range(1, 255), $urandom_range(0, 65535),
                        RANDOM_ITEMS / PHASES, 1'b0);
    test_random_traffic(LINK_TIMEOUT_RST, CONC_MAX_RST, RANDOM_ITEMS / PHASES, 1'b0);
    wait_idle(10);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/gsfc_pkg.sv
design/gsfc_in_if.sv
design/gsfc_out_if.sv
design/gsfc_scale.sv
design/gsfc_frame.sv
design/gas_sensor_frame_checker.sv
test/tb_gas_sensor_frame_checker.sv
